@@ src/mmed_pkg.sv @@
// shared types, constants and functions for the min/max envelope decimator
// no dependencies; used by mmed_fold, mmed_out and minmax_envelope_decimator
package mmed_pkg;

  localparam int SAMPLE_W = 16;
  localparam int MASK_W   = 64;
  localparam int CRC_W    = 32;
  localparam int SLOT_W   = 6;
  localparam int LEN_W    = SLOT_W + 1;

  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 16'sh8000;
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7fff;

  localparam logic [CRC_W-1:0] CRC_POLY = 32'hedb88320;
  localparam logic [CRC_W-1:0] CRC_INIT = 32'hffffffff;
  localparam logic [CRC_W-1:0] CRC_XOUT = 32'hffffffff;

  // window select codes
  localparam logic [1:0] WIN_4  = 2'd0;
  localparam logic [1:0] WIN_16 = 2'd1;
  localparam logic [1:0] WIN_64 = 2'd2;

  // register index on the config port
  localparam logic REG_WINDOW_SELECT = 1'b0;

  // one closed window, before the checksum
  typedef struct packed {
    logic                       bad;
    logic [MASK_W-1:0]          mask;
    logic signed [SAMPLE_W-1:0] high;
    logic signed [SAMPLE_W-1:0] low;
  } rec_t;

  // window length for a select code
  function automatic logic [LEN_W-1:0] win_len(input logic [1:0] sel);
    logic [LEN_W-1:0] len;
    case (sel)
      WIN_4:   len = 7'd4;
      WIN_16:  len = 7'd16;
      default: len = 7'd64;
    endcase
    return len;
  endfunction

  // reflected crc-32 over low, high, mask packed little-endian (96 bits);
  // linear in the data, so this flattens to a parallel xor network
  function automatic logic [CRC_W-1:0] crc_record(input logic [95:0] data);
    logic [CRC_W-1:0] crc;
    logic             fb;
    crc = CRC_INIT;
    for (int i = 0; i < 96; i++) begin
      fb  = crc[0] ^ data[i];
      crc = (crc >> 1) ^ (fb ? CRC_POLY : '0);
    end
    return crc ^ CRC_XOUT;
  endfunction

endpackage

@@ src/mmed_fold.sv @@
// envelope fold: window state, min/max update and record register
// depends on mmed_pkg
module mmed_fold #(
  parameter int MAX_WINDOW = 64
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic [1:0]                          win_sel,
  input  logic                                a_valid,
  input  logic signed [mmed_pkg::SAMPLE_W-1:0] a_low,
  input  logic signed [mmed_pkg::SAMPLE_W-1:0] a_high,
  input  logic                                a_last,
  output logic                                a_ready,
  output logic                                rec_valid,
  output mmed_pkg::rec_t                      rec,
  input  logic                                rec_ready
);

  localparam logic [mmed_pkg::LEN_W-1:0] MaxLen = mmed_pkg::LEN_W'(MAX_WINDOW);

  logic signed [mmed_pkg::SAMPLE_W-1:0] run_low_r, run_low_nxt;
  logic signed [mmed_pkg::SAMPLE_W-1:0] run_high_r, run_high_nxt;
  logic [mmed_pkg::MASK_W-1:0]          bits_r, bits_nxt;
  logic [mmed_pkg::SLOT_W-1:0]          slot_r, slot_nxt;
  logic                                 rec_valid_r, rec_valid_nxt;
  mmed_pkg::rec_t                       rec_r, rec_nxt;

  logic                                 b_ready, go;
  logic                                 lo_miss, hi_miss, gap, bad, close;
  logic signed [mmed_pkg::SAMPLE_W-1:0] lo_f, hi_f, new_low, new_high;
  logic [mmed_pkg::MASK_W-1:0]          new_bits;
  logic [mmed_pkg::LEN_W-1:0]           len_sel, len, slot_inc;

  assign b_ready = !rec_valid_r || rec_ready;
  assign go      = a_valid && b_ready;
  assign a_ready = b_ready;

  // window length, capped
  assign len_sel = mmed_pkg::win_len(win_sel);
  assign len     = (len_sel > MaxLen) ? MaxLen : len_sel;

  // missing halves copy each other
  assign lo_miss = (a_low == mmed_pkg::SAMPLE_MIN);
  assign hi_miss = (a_high == mmed_pkg::SAMPLE_MIN);
  assign gap     = lo_miss && hi_miss;
  assign lo_f    = lo_miss ? a_high : a_low;
  assign hi_f    = hi_miss ? a_low : a_high;
  assign bad     = !gap && (lo_f > hi_f);

  // envelope update
  assign new_low  = (!gap && lo_f < run_low_r) ? lo_f : run_low_r;
  assign new_high = (!gap && hi_f > run_high_r) ? hi_f : run_high_r;
  assign new_bits = gap ? bits_r : (bits_r | (mmed_pkg::MASK_W'(1) << slot_r));
  assign slot_inc = {1'b0, slot_r} + mmed_pkg::LEN_W'(1);
  assign close    = (slot_inc >= len) || a_last;

  // next state and record
  always_comb begin
    run_low_nxt   = run_low_r;
    run_high_nxt  = run_high_r;
    bits_nxt      = bits_r;
    slot_nxt      = slot_r;
    rec_nxt       = rec_r;
    rec_valid_nxt = rec_valid_r && !rec_ready;
    if (go) begin
      rec_valid_nxt = bad || close;
      if (bad) begin
        rec_nxt = '{bad: 1'b1, mask: '0, high: '0, low: '0};
      end else begin
        rec_nxt = '{bad: 1'b0, mask: new_bits, high: new_high, low: new_low};
      end
      if (bad || close) begin
        run_low_nxt  = mmed_pkg::SAMPLE_MAX;
        run_high_nxt = mmed_pkg::SAMPLE_MIN;
        bits_nxt     = '0;
        slot_nxt     = '0;
      end else begin
        run_low_nxt  = new_low;
        run_high_nxt = new_high;
        bits_nxt     = new_bits;
        slot_nxt     = slot_inc[mmed_pkg::SLOT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_low_r   <= mmed_pkg::SAMPLE_MAX;
      run_high_r  <= mmed_pkg::SAMPLE_MIN;
      bits_r      <= '0;
      slot_r      <= '0;
      rec_valid_r <= 1'b0;
    end else begin
      run_low_r   <= run_low_nxt;
      run_high_r  <= run_high_nxt;
      bits_r      <= bits_nxt;
      slot_r      <= slot_nxt;
      rec_valid_r <= rec_valid_nxt;
    end
    rec_r <= rec_nxt;
  end

  assign rec_valid = rec_valid_r;
  assign rec       = rec_r;

endmodule

@@ src/mmed_out.sv @@
// checksum stage and output register of the result stream
// depends on mmed_pkg
module mmed_out (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           rec_valid,
  input  mmed_pkg::rec_t rec,
  output logic           rec_ready,
  output logic           out_valid,
  output logic [127:0]   out_data,
  output logic           out_bad,
  input  logic           out_ready
);

  logic         out_valid_r, out_valid_nxt;
  logic [127:0] out_data_r, out_data_nxt;
  logic         out_bad_r, out_bad_nxt;
  logic [95:0]  packed_rec;
  logic [31:0]  crc;

  assign rec_ready  = !out_valid_r || out_ready;
  assign packed_rec = {rec.mask, rec.high, rec.low};

  // checksum, forced to zero on a bad record
  assign crc = rec.bad ? '0 : mmed_pkg::crc_record(packed_rec);

  always_comb begin
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    out_bad_nxt   = out_bad_r;
    if (rec_valid && rec_ready) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = {crc, packed_rec};
      out_bad_nxt   = rec.bad;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
    out_data_r <= out_data_nxt;
    out_bad_r  <= out_bad_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign out_bad   = out_bad_r;

endmodule

@@ src/minmax_envelope_decimator.sv @@
// min/max envelope decimator: input register, fold stage, checksum stage
// a closing word passes the input register, the record register and the output register to out_
// throughput: one word per cycle unless out_tready stalls; the three registered stages each hold one word
// reset (rst_n low, synchronous): window 4 samples, empty window, all stages empty
// depends on mmed_pkg, mmed_fold, mmed_out
module minmax_envelope_decimator #(
  parameter int MAX_WINDOW = 64
) (
  input  logic         clk,
  input  logic         rst_n,
  // input stream
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [31:0]  in_tdata,   // sample_low [15:0], sample_high [31:16]
  input  logic         in_tlast,   // end_of_source
  // result stream
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [127:0] out_tdata,  // window_low [15:0], window_high [31:16],
                                   // valid_mask [95:32], record_crc [127:96]
  output logic         out_tuser,  // bad_sample
  // config port
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [2:0]   cfg_paddr,
  input  logic [31:0]  cfg_pwdata,
  output logic [31:0]  cfg_prdata,
  output logic         cfg_pready
);

  logic        cfg_idx;
  logic [1:0]  sel_r, sel_nxt;
  logic        cfg_wr;

  logic        in_valid_r, in_valid_nxt;
  logic signed [15:0] in_low_r, in_high_r;
  logic        in_last_r;
  logic        a_ready;
  logic        rec_valid, rec_ready;
  mmed_pkg::rec_t rec;

  // config register
  assign cfg_pready = 1'b1;
  assign cfg_idx    = cfg_paddr[2];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign sel_nxt    = (cfg_wr && cfg_idx == mmed_pkg::REG_WINDOW_SELECT) ?
                      cfg_pwdata[1:0] : sel_r;
  assign cfg_prdata = (cfg_idx == mmed_pkg::REG_WINDOW_SELECT) ? {30'd0, sel_r} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sel_r <= mmed_pkg::WIN_4;
    end else begin
      sel_r <= sel_nxt;
    end
  end

  // input register
  assign in_tready    = !in_valid_r || a_ready;
  assign in_valid_nxt = in_tready ? in_tvalid : in_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else begin
      in_valid_r <= in_valid_nxt;
    end
    if (in_tready) begin
      in_low_r  <= in_tdata[15:0];
      in_high_r <= in_tdata[31:16];
      in_last_r <= in_tlast;
    end
  end

  mmed_fold #(
    .MAX_WINDOW(MAX_WINDOW)
  ) u_fold (
    .clk       (clk),
    .rst_n     (rst_n),
    .win_sel   (sel_r),
    .a_valid   (in_valid_r),
    .a_low     (in_low_r),
    .a_high    (in_high_r),
    .a_last    (in_last_r),
    .a_ready   (a_ready),
    .rec_valid (rec_valid),
    .rec       (rec),
    .rec_ready (rec_ready)
  );

  mmed_out u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .rec_valid (rec_valid),
    .rec       (rec),
    .rec_ready (rec_ready),
    .out_valid (out_tvalid),
    .out_data  (out_tdata),
    .out_bad   (out_tuser),
    .out_ready (out_tready)
  );

  // a bad record carries all-zero contents and checksum
  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata == '0)
    else $error("bad record with nonzero contents");

  // an empty window reports the empty envelope
  a_empty_env: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser && out_tdata[95:32] == '0 |->
      out_tdata[15:0] == 16'h7fff && out_tdata[31:16] == 16'h8000)
    else $error("empty window with wrong envelope");

  // a window with samples has low not above high
  a_env_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser && out_tdata[95:32] != '0 |->
      $signed(out_tdata[15:0]) <= $signed(out_tdata[31:16]))
    else $error("envelope low above high");

endmodule

@@ dv/tb_minmax_envelope_decimator.sv @@
// self-checking testbench for minmax_envelope_decimator: stream driver, result monitor,
// apb register writes and an envelope/crc predictor
// depends on mmed_pkg and the minmax_envelope_decimator rtl
`timescale 1ns / 1ps

module tb_minmax_envelope_decimator;

  localparam int          LIMIT_CYCLES = 1_000_000;
  localparam int          DRAIN_CYCLES = 8;
  localparam int          HOLD_CYCLES  = 400;
  localparam int          PHASE_PAIRS  = 150;
  localparam logic [1:0]  WIN_64_ALT   = 2'd3;  // unused code, behaves as 64

  typedef struct packed {
    logic                                 last;
    logic signed [mmed_pkg::SAMPLE_W-1:0] high;
    logic signed [mmed_pkg::SAMPLE_W-1:0] low;
  } sample_pair_t;

  typedef struct packed {
    logic                                 bad;
    logic [mmed_pkg::CRC_W-1:0]           crc;
    logic [mmed_pkg::MASK_W-1:0]          mask;
    logic signed [mmed_pkg::SAMPLE_W-1:0] high;
    logic signed [mmed_pkg::SAMPLE_W-1:0] low;
  } envelope_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [31:0]  in_tdata = '0;
  logic         in_tlast = 1'b0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [127:0] out_tdata;
  logic         out_tuser;
  logic         cfg_psel = 1'b0;
  logic         cfg_penable = 1'b0;
  logic         cfg_pwrite = 1'b0;
  logic [2:0]   cfg_paddr = '0;
  logic [31:0]  cfg_pwdata = '0;
  logic [31:0]  cfg_prdata;
  logic         cfg_pready;

  minmax_envelope_decimator uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  // 12 ns clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // predictor state, mirrors the block after reset
  logic [1:0]                           win_sel  = mmed_pkg::WIN_4;
  logic signed [mmed_pkg::SAMPLE_W-1:0] env_low  = mmed_pkg::SAMPLE_MAX;
  logic signed [mmed_pkg::SAMPLE_W-1:0] env_high = mmed_pkg::SAMPLE_MIN;
  logic [mmed_pkg::MASK_W-1:0]          env_mask = '0;
  logic [6:0]                           env_slot = '0;

  sample_pair_t pending_pairs[$];
  envelope_t    expected_records[$];

  int   mismatches = 0;
  int   cycle_count = 0;
  logic in_took = 1'b0;
  logic tx_gaps_on = 1'b1;
  logic rx_gaps_on = 1'b1;
  int   rx_hold_trigger = 0;

  // gap length: mostly none or short, now and then long
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic sample_pair_t pair(input logic signed [15:0] lo,
                                        input logic signed [15:0] hi, input logic last);
    sample_pair_t p;
    p.low  = lo;
    p.high = hi;
    p.last = last;
    return p;
  endfunction

  // extremes, small values around zero, or full range
  function automatic logic signed [15:0] pick_value();
    int r;
    int s;
    r = $urandom_range(0, 99);
    if (r < 10) begin
      case ($urandom_range(0, 5))
        0: return mmed_pkg::SAMPLE_MIN;
        1: return mmed_pkg::SAMPLE_MIN + 16'sd1;
        2: return -16'sd1;
        3: return 16'sd0;
        4: return 16'sd1;
        default: return mmed_pkg::SAMPLE_MAX;
      endcase
    end
    if (r < 40) begin
      s = $urandom_range(0, 200);
      return 16'(s - 100);
    end
    return 16'($urandom);
  endfunction

  // mostly ordered pairs, some reversed, missing halves and gaps
  function automatic sample_pair_t random_pair();
    logic signed [15:0] a;
    logic signed [15:0] b;
    logic signed [15:0] t;
    int kind;
    a = pick_value();
    b = pick_value();
    if (a > b) begin
      t = a;
      a = b;
      b = t;
    end
    kind = $urandom_range(0, 99);
    if (kind < 6) return pair(b, a, $urandom_range(0, 99) < 3);
    if (kind < 13) return pair(mmed_pkg::SAMPLE_MIN, b, $urandom_range(0, 99) < 3);
    if (kind < 20) return pair(a, mmed_pkg::SAMPLE_MIN, $urandom_range(0, 99) < 3);
    if (kind < 25) begin
      return pair(mmed_pkg::SAMPLE_MIN, mmed_pkg::SAMPLE_MIN, $urandom_range(0, 99) < 3);
    end
    return pair(a, b, $urandom_range(0, 99) < 3);
  endfunction

  // reflected crc-32 over low, high, mask as 12 little-endian bytes
  function automatic logic [mmed_pkg::CRC_W-1:0] record_crc32(input logic [15:0] lo,
                                                              input logic [15:0] hi,
                                                              input logic [63:0] mask);
    logic [95:0]                bytes;
    logic [mmed_pkg::CRC_W-1:0] c;
    bytes = {mask, hi, lo};
    c = 32'hffffffff;
    for (int k = 0; k < 12; k++) begin
      c ^= {24'd0, bytes[8*k +: 8]};
      for (int b = 0; b < 8; b++) c = c[0] ? ((c >> 1) ^ mmed_pkg::CRC_POLY) : (c >> 1);
    end
    return ~c;
  endfunction

  task automatic restart_envelope();
    env_low  = mmed_pkg::SAMPLE_MAX;
    env_high = mmed_pkg::SAMPLE_MIN;
    env_mask = '0;
    env_slot = '0;
  endtask

  // fold one accepted pair into the envelope, queue the record it closes
  task automatic fold_pair(input sample_pair_t p);
    logic signed [15:0] lo;
    logic signed [15:0] hi;
    logic [6:0]         len;
    envelope_t          rec;
    lo = p.low;
    hi = p.high;
    case (win_sel)
      mmed_pkg::WIN_4:  len = 7'd4;
      mmed_pkg::WIN_16: len = 7'd16;
      default:          len = 7'd64;
    endcase
    if (!(lo == mmed_pkg::SAMPLE_MIN && hi == mmed_pkg::SAMPLE_MIN)) begin
      if (lo == mmed_pkg::SAMPLE_MIN) lo = hi;
      if (hi == mmed_pkg::SAMPLE_MIN) hi = lo;
      // reversed pair: flagged record, window starts over even on end of source
      if (lo > hi) begin
        rec = '0;
        rec.bad = 1'b1;
        expected_records.push_back(rec);
        restart_envelope();
        return;
      end
      if (lo < env_low) env_low = lo;
      if (hi > env_high) env_high = hi;
      env_mask[env_slot[5:0]] = 1'b1;
    end
    env_slot = env_slot + 7'd1;
    if (env_slot >= len || p.last) begin
      rec.low  = env_low;
      rec.high = env_high;
      rec.mask = env_mask;
      rec.crc  = record_crc32(env_low, env_high, env_mask);
      rec.bad  = 1'b0;
      expected_records.push_back(rec);
      restart_envelope();
    end
  endtask

  // input driver
  int in_gap = 0;
  always @(negedge clk) begin : in_driver
    sample_pair_t p;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!(in_tvalid && !in_took)) begin
      if (in_gap > 0) begin
        in_gap    <= in_gap - 1;
        in_tvalid <= 1'b0;
      end else if (pending_pairs.size() > 0) begin
        p = pending_pairs.pop_front();
        in_tdata  <= {p.high, p.low};
        in_tlast  <= p.last;
        in_tvalid <= 1'b1;
        in_gap    <= tx_gaps_on ? gap_len() : 0;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // result receiver with random stalls and a long hold on request
  int rx_gap = 0;
  int rx_hold_left = 0;
  int rx_hold_seen = 0;
  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (rx_hold_seen != rx_hold_trigger) begin
      rx_hold_seen <= rx_hold_trigger;
      rx_hold_left <= HOLD_CYCLES;
      out_tready   <= 1'b0;
    end else if (rx_hold_left > 0) begin
      rx_hold_left <= rx_hold_left - 1;
      out_tready   <= 1'b0;
    end else if (rx_gap > 0) begin
      rx_gap     <= rx_gap - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
      rx_gap     <= rx_gaps_on ? gap_len() : 0;
    end
  end

  // monitor: predict on input accept, compare on result accept
  always @(posedge clk) begin : monitor
    envelope_t got;
    envelope_t want;
    in_took <= rst_n && in_tvalid && in_tready;
    if (rst_n && out_tvalid && out_tready) begin
      got.low  = out_tdata[15:0];
      got.high = out_tdata[31:16];
      got.mask = out_tdata[95:32];
      got.crc  = out_tdata[127:96];
      got.bad  = out_tuser;
      if (expected_records.size() == 0) begin
        if (mismatches < 10)
          $display("unexpected word: low %0d high %0d mask %h crc %h bad %b",
                   got.low, got.high, got.mask, got.crc, got.bad);
        mismatches++;
      end else begin
        want = expected_records.pop_front();
        if (got.low !== want.low || got.high !== want.high || got.mask !== want.mask ||
            got.crc !== want.crc || got.bad !== want.bad) begin
          if (mismatches < 10) begin
            $display("mismatch: expected low %0d high %0d mask %h crc %h bad %b",
                     want.low, want.high, want.mask, want.crc, want.bad);
            $display("          actual   low %0d high %0d mask %h crc %h bad %b",
                     got.low, got.high, got.mask, got.crc, got.bad);
          end
          mismatches++;
        end
      end
    end
    if (rst_n && in_tvalid && in_tready)
      fold_pair(pair(in_tdata[15:0], in_tdata[31:16], in_tlast));
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // apb write: setup phase, then access phase
  task automatic write_window_select(input logic [1:0] sel);
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= 3'(4 * mmed_pkg::REG_WINDOW_SELECT);
    cfg_pwdata  <= {30'd0, sel};
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    win_sel = sel;
  endtask

  // wait until every pair is taken and every record is back, then let the pipe settle
  task automatic wait_idle();
    do @(posedge clk); while (pending_pairs.size() != 0 || in_tvalid);
    do @(negedge clk); while (expected_records.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  logic [1:0] phase_sel[8] = '{mmed_pkg::WIN_16, mmed_pkg::WIN_64, WIN_64_ALT,
                               mmed_pkg::WIN_4, mmed_pkg::WIN_64, mmed_pkg::WIN_16,
                               mmed_pkg::WIN_4, mmed_pkg::WIN_64};

  initial begin
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    // directed words at the reset window of 4
    pending_pairs.push_back(pair(16'sd100, 16'sd200, 1'b0));
    pending_pairs.push_back(pair(mmed_pkg::SAMPLE_MIN, 16'sd50, 1'b0));   // missing low
    pending_pairs.push_back(pair(16'sd40, mmed_pkg::SAMPLE_MIN, 1'b0));   // missing high
    // gap closes window
    pending_pairs.push_back(pair(mmed_pkg::SAMPLE_MIN, mmed_pkg::SAMPLE_MIN, 1'b0));
    pending_pairs.push_back(pair(mmed_pkg::SAMPLE_MIN + 16'sd1, mmed_pkg::SAMPLE_MAX, 1'b0));
    pending_pairs.push_back(pair(mmed_pkg::SAMPLE_MAX, mmed_pkg::SAMPLE_MAX, 1'b0));
    // end of source mid window
    pending_pairs.push_back(pair(mmed_pkg::SAMPLE_MIN, mmed_pkg::SAMPLE_MIN, 1'b1));
    // empty window
    repeat (4) pending_pairs.push_back(pair(mmed_pkg::SAMPLE_MIN, mmed_pkg::SAMPLE_MIN, 1'b0));
    pending_pairs.push_back(pair(16'sd10, 16'sd5, 1'b0));       // reversed pair
    pending_pairs.push_back(pair(16'sd1, 16'sd2, 1'b0));
    pending_pairs.push_back(pair(16'sd5, 16'sd3, 1'b1));        // reversed with end of source
    pending_pairs.push_back(pair(mmed_pkg::SAMPLE_MAX, mmed_pkg::SAMPLE_MIN + 16'sd1, 1'b0));
    pending_pairs.push_back(pair(16'sd0, 16'sd0, 1'b0));
    pending_pairs.push_back(pair(-16'sd1, -16'sd1, 1'b1));
    pending_pairs.push_back(pair(mmed_pkg::SAMPLE_MIN, mmed_pkg::SAMPLE_MAX, 1'b0));
    pending_pairs.push_back(pair(mmed_pkg::SAMPLE_MIN + 16'sd1, mmed_pkg::SAMPLE_MIN, 1'b1));
    pending_pairs.push_back(pair(-16'sd1, 16'sd0, 1'b0));       // left open across the switch
    wait_idle();

    // random phases, each after a window select write; windows may stay open across writes
    for (int ph = 0; ph < 8; ph++) begin
      tx_gaps_on = !(ph == 2 || ph == 4);
      rx_gaps_on = (ph != 4);
      write_window_select(phase_sel[ph]);
      for (int n = 0; n < PHASE_PAIRS; n++) pending_pairs.push_back(random_pair());
      // open tail so the next write may land mid window
      repeat (5) pending_pairs.push_back(pair(pick_value() & 16'sh3fff, 16'sh4000, 1'b0));
      if (ph == 2) rx_hold_trigger++;
      wait_idle();
    end

    repeat (DRAIN_CYCLES * 2) @(negedge clk);
    if (mismatches == 0 && expected_records.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
